// File: design/lzwc_pkg.sv
// Package for the LZW compressor: shared constants, register map and the
// table control group. No dependencies.
package lzwc_pkg;

    localparam int START_WIDTH        = 9;
    localparam int DEF_TOP_WIDTH      = 13;
    localparam int DEF_HASH_SLOTS     = 9029;

    localparam int CNT_W              = 32;
    localparam int RATIO_W            = 16;
    localparam int DIVD_W             = 39;
    localparam int APB_ADDR_W         = 2;

    localparam int CODE_CLEAR         = 256;
    localparam int CODE_END           = 257;
    localparam int CODE_FIRST         = 258;
    localparam int RATIO_INIT         = 100;

    localparam logic [15:0] DEF_CHECK_INTERVAL = 16'd100;
    localparam logic [APB_ADDR_W-1:0] ADDR_CHECK_INTERVAL = 2'd0;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } tbl_ctl_t;

endpackage

// File: design/lzwc_if.sv
// Valid/ready channel interfaces for the LZW compressor: raw byte input
// and packed code byte output. No dependencies.
interface lzwc_raw_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface lzwc_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;

    modport source (output valid, output out_byte, output run_last, output stream_done,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input stream_done,
                    output ready);
endinterface

// File: design/lzw_variable_width_compressor_top.sv
// LZW compressor top level: byte-in, code-byte-out sequencer, APB register.
// Depends on lzwc_pkg, lzwc_if, lzwc_table and lzwc_div.
//
// Takes one uncompressed byte per beat on raw and returns LZW codes packed
// MSB first as bytes on codes; run_last marks the last byte caused by an
// input beat and stream_done the final byte of a stream. Codes start 9 bits
// wide and grow to TOP_WIDTH. The dictionary is a HASH_SLOTS-entry table in
// one single-port-read memory searched by secondary probing; each probe
// issues the address, then compares the registered read. Once the table is
// full, every check_interval bytes a ratio check runs a bit-serial divider.
// After reset, after a stream ends and after a clear code, the table is
// swept clean, one entry per cycle (HASH_SLOTS entries, 9029 by default),
// during which raw is not ready; register writes are taken meanwhile.
// check_interval lives at byte address 0 of the APB port. Output bytes sit
// in a one-beat output register, with one more byte held back so that
// run_last is known when it is sent.
module lzw_variable_width_compressor_top
    import lzwc_pkg::*;
#(
    parameter int TOP_WIDTH  = DEF_TOP_WIDTH,
    parameter int HASH_SLOTS = DEF_HASH_SLOTS
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    lzwc_raw_if.sink              raw,
    lzwc_code_if.source           codes
);
    localparam int IDX_W  = $clog2(HASH_SLOTS);
    localparam int HASH_W = (TOP_WIDTH > IDX_W) ? TOP_WIDTH : IDX_W;
    localparam int NFC_W  = TOP_WIDTH + 1;
    localparam int WID_W  = $clog2(TOP_WIDTH + 2);
    localparam int PCNT_W = $clog2(HASH_SLOTS + 1);
    localparam int WORD_W = 1 + 2 * TOP_WIDTH + 8;

    localparam logic [IDX_W:0]    SLOTS_V  = (IDX_W + 1)'(HASH_SLOTS);
    localparam logic [HASH_W-1:0] SLOTS_H  = HASH_W'(HASH_SLOTS);
    localparam logic [PCNT_W-1:0] SLOTS_P  = PCNT_W'(HASH_SLOTS);
    localparam logic [NFC_W-1:0]  NFC_MAX  = {1'b1, {TOP_WIDTH{1'b0}}};
    localparam logic [WID_W-1:0]  W_START  = WID_W'(START_WIDTH);
    localparam logic [WID_W-1:0]  W_TOP    = WID_W'(TOP_WIDTH);

    typedef enum logic [16:0] {
        S_CLEAR   = 17'h00001,
        S_IDLE    = 17'h00002,
        S_HASH    = 17'h00004,
        S_RD      = 17'h00008,
        S_CHK     = 17'h00010,
        S_MISS    = 17'h00020,
        S_DRAIN   = 17'h00040,
        S_GROW    = 17'h00080,
        S_DIVLD   = 17'h00100,
        S_DIVW    = 17'h00200,
        S_RATIO   = 17'h00400,
        S_CLRDONE = 17'h00800,
        S_FIN     = 17'h01000,
        S_FIN2    = 17'h02000,
        S_FIN3    = 17'h04000,
        S_ZERO    = 17'h08000,
        S_FLUSH   = 17'h10000
    } state_t;

    state_t             state_reg, state_next, ret_reg, ret_next;
    logic [7:0]         ch_reg, ch_next;
    logic               last_reg, last_next;
    logic               started_reg, started_next;
    logic [TOP_WIDTH-1:0] cur_reg, cur_next;
    logic [NFC_W-1:0]   nfc_reg, nfc_next;
    logic [WID_W-1:0]   width_reg, width_next;
    logic [CNT_W-1:0]   cin_reg, cin_next;
    logic [CNT_W-1:0]   cout_reg, cout_next;
    logic [CNT_W-1:0]   nck_reg, nck_next;
    logic [RATIO_W-1:0] prev_reg, prev_next;
    logic [31:0]        acc_reg, acc_next;
    logic [5:0]         held_reg, held_next;
    logic [15:0]        interval_reg;
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [PCNT_W-1:0]  pcnt_reg, pcnt_next;
    logic               room_reg, room_next;
    logic               need_clear_reg, need_clear_next;
    logic [1:0]         zcnt_reg, zcnt_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [7:0]         pend_byte_reg, pend_byte_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    logic               out_done_reg, out_done_next;

    tbl_ctl_t           tbl_ctl;
    logic [WORD_W-1:0]  tbl_wr_data;
    logic [WORD_W-1:0]  tbl_rd_data;
    logic               tbl_busy;

    logic               div_start;
    logic               div_done;
    logic [DIVD_W-1:0]  div_quo;
    logic [DIVD_W-1:0]  div_dividend;

    logic               send_en;
    logic [TOP_WIDTH-1:0] send_val;
    logic [31:0]        send_mask;
    logic [5:0]         send_sh;
    logic [NFC_W-1:0]   top_code;
    logic               out_free;
    logic [HASH_W-1:0]  raw_hash;
    logic [IDX_W-1:0]   red_idx;
    logic [IDX_W-1:0]   probe_next_idx;
    logic               slot_valid;
    logic [TOP_WIDTH-1:0] slot_code;
    logic [TOP_WIDTH-1:0] slot_prefix;
    logic [7:0]         slot_char;
    state_t             after_st;

    // APB register: check_interval at address 0
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CHECK_INTERVAL) ? {16'd0, interval_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= DEF_CHECK_INTERVAL;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_CHECK_INTERVAL))
        begin
            interval_reg <= pwdata[15:0];
        end
    end

    assign raw.ready         = (state_reg == S_IDLE);
    assign codes.valid       = out_valid_reg;
    assign codes.out_byte    = out_byte_reg;
    assign codes.run_last    = out_last_reg;
    assign codes.stream_done = out_done_reg;

    assign out_free = !out_valid_reg || codes.ready;
    assign top_code = (NFC_W'(1) << width_reg) - NFC_W'(1);

    // hash of (current string, new byte)
    assign raw_hash = HASH_W'({raw.data_byte, {(TOP_WIDTH - 8){1'b0}}}) ^ HASH_W'(cur_reg);
    assign red_idx  = hash_reg[IDX_W-1:0];
    assign probe_next_idx = (idx_reg >= step_reg) ? (idx_reg - step_reg)
                          : IDX_W'({1'b0, idx_reg} + SLOTS_V - {1'b0, step_reg});

    assign slot_valid  = tbl_rd_data[WORD_W-1];
    assign slot_code   = tbl_rd_data[WORD_W-2 -: TOP_WIDTH];
    assign slot_prefix = tbl_rd_data[8 +: TOP_WIDTH];
    assign slot_char   = tbl_rd_data[7:0];

    assign after_st = last_reg ? S_FIN : S_FLUSH;

    // count_out * 100 as shifts and adds
    assign div_dividend = {1'b0, cout_reg, 6'd0} + {2'd0, cout_reg, 5'd0}
                        + {5'd0, cout_reg, 2'd0};

    // bit packer: place the code just below the bits already held
    assign send_mask = (32'd1 << width_reg) - 32'd1;
    assign send_sh   = 6'd32 - 6'(width_reg) - held_reg;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        ch_next         = ch_reg;
        last_next       = last_reg;
        started_next    = started_reg;
        cur_next        = cur_reg;
        nfc_next        = nfc_reg;
        width_next      = width_reg;
        cin_next        = cin_reg;
        cout_next       = cout_reg;
        nck_next        = nck_reg;
        prev_next       = prev_reg;
        acc_next        = acc_reg;
        held_next       = held_reg;
        hash_next       = hash_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        pcnt_next       = pcnt_reg;
        room_next       = room_reg;
        need_clear_next = need_clear_reg;
        zcnt_next       = zcnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        tbl_ctl         = '0;
        tbl_wr_data     = {1'b1, nfc_reg[TOP_WIDTH-1:0], cur_reg, ch_reg};
        div_start       = 1'b0;
        send_en         = 1'b0;
        send_val        = cur_reg;

        // drop the output beat once taken
        if (out_valid_reg && codes.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                if (!tbl_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (raw.valid)
                begin
                    ch_next   = raw.data_byte;
                    last_next = raw.end_of_stream;
                    if (!started_reg)
                    begin
                        // first byte of a stream: restore counters
                        width_next   = W_START;
                        nfc_next     = NFC_W'(CODE_FIRST);
                        cin_next     = '0;
                        cout_next    = '0;
                        nck_next     = CNT_W'(interval_reg);
                        prev_next    = RATIO_W'(RATIO_INIT);
                        acc_next     = '0;
                        held_next    = '0;
                        cur_next     = TOP_WIDTH'(raw.data_byte);
                        started_next = 1'b1;
                        state_next   = raw.end_of_stream ? S_FIN : S_FLUSH;
                    end
                    else
                    begin
                        cin_next   = cin_reg + CNT_W'(1);
                        hash_next  = raw_hash;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_reg >= SLOTS_H)
                begin
                    hash_next = hash_reg - SLOTS_H;
                end
                else
                begin
                    idx_next   = red_idx;
                    step_next  = (red_idx == '0) ? IDX_W'(1)
                               : IDX_W'(SLOTS_V - {1'b0, red_idx});
                    pcnt_next  = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (pcnt_reg == SLOTS_P)
                begin
                    // every slot visited: no match, no room
                    room_next  = 1'b0;
                    state_next = S_MISS;
                end
                else
                begin
                    tbl_ctl.rd_en = 1'b1;
                    state_next    = S_CHK;
                end
            end
            S_CHK:
            begin
                if (!slot_valid)
                begin
                    room_next  = 1'b1;
                    state_next = S_MISS;
                end
                else if (slot_prefix == cur_reg && slot_char == ch_reg)
                begin
                    cur_next   = slot_code;
                    state_next = after_st;
                end
                else
                begin
                    idx_next   = probe_next_idx;
                    pcnt_next  = pcnt_reg + PCNT_W'(1);
                    state_next = S_RD;
                end
            end
            S_MISS:
            begin
                if (nfc_reg <= top_code && room_reg)
                begin
                    tbl_ctl.wr_en = 1'b1;
                    nfc_next      = nfc_reg + NFC_W'(1);
                end
                send_en    = 1'b1;
                send_val   = cur_reg;
                cur_next   = TOP_WIDTH'(ch_reg);
                ret_next   = S_GROW;
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (held_reg >= 6'd8)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = pend_byte_reg;
                            out_last_next  = 1'b0;
                            out_done_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_byte_next  = acc_reg[31:24];
                        acc_next        = {acc_reg[23:0], 8'd0};
                        held_next       = held_reg - 6'd8;
                        cout_next       = cout_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            S_GROW:
            begin
                state_next = after_st;
                if (nfc_reg > top_code)
                begin
                    if (width_reg < W_TOP)
                    begin
                        width_next = width_reg + WID_W'(1);
                    end
                    else if (cin_reg > nck_reg)
                    begin
                        state_next = S_DIVLD;
                    end
                end
            end
            S_DIVLD:
            begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = S_RATIO;
                end
            end
            S_RATIO:
            begin
                if (div_quo > DIVD_W'(prev_reg))
                begin
                    // ratio got worse: send clear code, then restart
                    send_en    = 1'b1;
                    send_val   = TOP_WIDTH'(CODE_CLEAR);
                    ret_next   = S_CLRDONE;
                    state_next = S_DRAIN;
                end
                else
                begin
                    prev_next  = (|div_quo[DIVD_W-1:RATIO_W]) ? '1 : div_quo[RATIO_W-1:0];
                    nck_next   = cin_reg + CNT_W'(interval_reg);
                    state_next = after_st;
                end
            end
            S_CLRDONE:
            begin
                width_next      = W_START;
                nfc_next        = NFC_W'(CODE_FIRST);
                cin_next        = '0;
                cout_next       = '0;
                prev_next       = RATIO_W'(RATIO_INIT);
                nck_next        = CNT_W'(interval_reg);
                need_clear_next = 1'b1;
                state_next      = after_st;
            end
            S_FIN:
            begin
                send_en    = 1'b1;
                send_val   = cur_reg;
                ret_next   = S_FIN2;
                state_next = S_DRAIN;
            end
            S_FIN2:
            begin
                // end bump: next code would not fit the current width
                if (nfc_reg == top_code)
                begin
                    width_next = width_reg + WID_W'(1);
                end
                zcnt_next  = '0;
                state_next = S_FIN3;
            end
            S_FIN3:
            begin
                send_en    = 1'b1;
                send_val   = TOP_WIDTH'(CODE_END);
                ret_next   = S_ZERO;
                state_next = S_DRAIN;
            end
            S_ZERO:
            begin
                if (zcnt_reg == 2'd3)
                begin
                    // drop the leftover bits and close the stream
                    acc_next        = '0;
                    held_next       = '0;
                    started_next    = 1'b0;
                    need_clear_next = 1'b1;
                    state_next      = S_FLUSH;
                end
                else
                begin
                    send_en    = 1'b1;
                    send_val   = '0;
                    zcnt_next  = zcnt_reg + 2'd1;
                    ret_next   = S_ZERO;
                    state_next = S_DRAIN;
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_byte_next   = pend_byte_reg;
                        out_last_next   = 1'b1;
                        out_done_next   = last_reg;
                        pend_valid_next = 1'b0;
                    end
                    if (need_clear_reg)
                    begin
                        tbl_ctl.clear   = 1'b1;
                        need_clear_next = 1'b0;
                        state_next      = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        if (send_en)
        begin
            acc_next  = acc_reg | ((32'(send_val) & send_mask) << send_sh);
            held_next = held_reg + 6'(width_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            ret_reg        <= S_IDLE;
            started_reg    <= 1'b0;
            cur_reg        <= '0;
            nfc_reg        <= NFC_W'(CODE_FIRST);
            width_reg      <= W_START;
            cin_reg        <= '0;
            cout_reg       <= '0;
            nck_reg        <= CNT_W'(100);
            prev_reg       <= RATIO_W'(RATIO_INIT);
            acc_reg        <= '0;
            held_reg       <= '0;
            need_clear_reg <= 1'b0;
            zcnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            started_reg    <= started_next;
            cur_reg        <= cur_next;
            nfc_reg        <= nfc_next;
            width_reg      <= width_next;
            cin_reg        <= cin_next;
            cout_reg       <= cout_next;
            nck_reg        <= nck_next;
            prev_reg       <= prev_next;
            acc_reg        <= acc_next;
            held_reg       <= held_next;
            need_clear_reg <= need_clear_next;
            zcnt_reg       <= zcnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        hash_reg      <= hash_next;
        idx_reg       <= idx_next;
        step_reg      <= step_next;
        pcnt_reg      <= pcnt_next;
        room_reg      <= room_next;
        pend_byte_reg <= pend_byte_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

    lzwc_table #(
        .DEPTH  (HASH_SLOTS),
        .WORD_W (WORD_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tbl_ctl),
        .rd_addr (idx_reg),
        .wr_addr (idx_reg),
        .wr_data (tbl_wr_data),
        .rd_data (tbl_rd_data),
        .busy    (tbl_busy)
    );

    lzwc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cin_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

`ifndef NO_ASSERTIONS
    a_held_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (held_reg < 6'd8))
        else $error("bits left undrained between input beats");

    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        (width_reg >= W_START) && (width_reg <= W_TOP + WID_W'(1)))
        else $error("code width out of range");

    a_nfc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nfc_reg <= NFC_MAX)
        else $error("next free code past the last code");

    a_no_access_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_busy |-> !(tbl_ctl.rd_en || tbl_ctl.wr_en))
        else $error("table access during clearing sweep");

    a_pend_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("held-back byte left over after an input beat");
`endif

endmodule

// File: design/lzwc_table.sv
// Hash table memory of the LZW compressor with its clearing sweep.
// Depends on lzwc_pkg.
module lzwc_table
    import lzwc_pkg::*;
#(
    parameter int DEPTH  = DEF_HASH_SLOTS,
    parameter int WORD_W = 1 + 2 * DEF_TOP_WIDTH + 8
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  tbl_ctl_t                 ctl,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WORD_W-1:0]        wr_data,
    output logic [WORD_W-1:0]        rd_data,
    output logic                     busy
);
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic              busy_reg, busy_next;

    always_comb
    begin
        sweep_next = sweep_reg;
        busy_next  = busy_reg;
        if (ctl.clear)
        begin
            busy_next  = 1'b1;
            sweep_next = '0;
        end
        else if (busy_reg)
        begin
            sweep_next = sweep_reg + AW'(1);
            if (sweep_reg == LAST_ADDR)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            sweep_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            sweep_reg <= sweep_next;
        end
    end

    // sweep owns the write port while busy
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[sweep_reg] <= '0;
        end
        else if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// File: design/lzwc_div.sv
// Restoring divider, one quotient bit per cycle, for the ratio check.
// Depends on lzwc_pkg.
module lzwc_div
    import lzwc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);
    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = STEP_W'(DIVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[CNT_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: test/lzwc_stream_checker.sv
`timescale 1ns / 100ps
// Stream checker for the LZW compressor: follows raw, codes and APB writes,
// predicts the packed code bytes and compares them. Depends on lzwc_pkg, lzwc_if.
module lzwc_stream_checker
    import lzwc_pkg::*;
#(
    parameter int TOP_WIDTH  = DEF_TOP_WIDTH,
    parameter int HASH_SLOTS = DEF_HASH_SLOTS
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    lzwc_raw_if                   raw,
    lzwc_code_if                  codes,
    output int                    failures,
    output int                    pending
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_done;
    } code_beat_t;

    code_beat_t expected_bytes[$];
    code_beat_t beat_bytes[$];

    logic                 slot_used   [HASH_SLOTS];
    logic [TOP_WIDTH-1:0] slot_code   [HASH_SLOTS];
    logic [TOP_WIDTH-1:0] slot_prefix [HASH_SLOTS];
    logic [7:0]           slot_char   [HASH_SLOTS];

    logic [TOP_WIDTH-1:0] cur_string;
    logic [13:0]          free_code;
    logic [3:0]           width;
    logic [31:0]          n_in;
    logic [31:0]          n_out;
    logic [31:0]          checkpoint;
    logic [15:0]          last_ratio;
    logic [31:0]          acc;
    logic [5:0]           held;
    logic                 started;
    logic [15:0]          interval;

    task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
        $display("%0t mismatch: %s expected %0h got %0h", $time, what, exp_v, got_v);
        failures++;
    endtask

    function automatic void wipe_table();
        for (int i = 0; i < HASH_SLOTS; i++)
            slot_used[i] = 1'b0;
    endfunction

    function automatic logic [31:0] top_code();
        return (32'd1 << width) - 32'd1;
    endfunction

    // Pack one code MSB first; every full byte becomes an expected beat.
    function automatic void pack_code(input logic [31:0] code);
        logic [31:0] mask;
        mask = (32'd1 << width) - 32'd1;
        acc  = acc | ((code & mask) << (32 - int'(width) - int'(held)));
        held = held + 6'(width);
        while (held >= 6'd8)
        begin
            beat_bytes.push_back('{acc[31:24], 1'b0, 1'b0});
            acc   = acc << 8;
            held  = held - 6'd8;
            n_out = n_out + 32'd1;
        end
    endfunction

    function automatic int seek_slot(input logic [31:0] prefix, input logic [31:0] ch,
                                     output bit hit, output bit room);
        int idx;
        int stride;
        idx    = int'(((ch << (TOP_WIDTH - 8)) ^ prefix) % HASH_SLOTS);
        stride = (idx == 0) ? 1 : HASH_SLOTS - idx;
        for (int n = 0; n < HASH_SLOTS; n++)
        begin
            if (!slot_used[idx])
            begin
                hit  = 0;
                room = 1;
                return idx;
            end
            if (slot_prefix[idx] == prefix[TOP_WIDTH-1:0] && slot_char[idx] == ch[7:0])
            begin
                hit  = 1;
                room = 0;
                return idx;
            end
            idx = (idx >= stride) ? idx - stride : idx + HASH_SLOTS - stride;
        end
        hit  = 0;
        room = 0;
        return 0;
    endfunction

    function automatic void open_stream(input logic [7:0] ch);
        wipe_table();
        width      = 4'(START_WIDTH);
        free_code  = 14'(CODE_FIRST);
        n_in       = '0;
        n_out      = '0;
        checkpoint = {16'd0, interval};
        last_ratio = 16'(RATIO_INIT);
        acc        = '0;
        held       = '0;
        cur_string = TOP_WIDTH'(ch);
        started    = 1'b1;
    endfunction

    function automatic void absorb_byte(input logic [7:0] ch);
        int   idx;
        bit   hit;
        bit   room;
        logic [63:0] ratio;
        n_in = n_in + 32'd1;
        idx  = seek_slot(32'(cur_string), 32'(ch), hit, room);
        if (hit)
        begin
            cur_string = slot_code[idx];
            return;
        end
        if (32'(free_code) <= top_code() && room)
        begin
            slot_used[idx]   = 1'b1;
            slot_code[idx]   = TOP_WIDTH'(free_code);
            slot_prefix[idx] = cur_string;
            slot_char[idx]   = ch;
            free_code        = free_code + 14'd1;
        end
        pack_code(32'(cur_string));
        cur_string = TOP_WIDTH'(ch);
        if (32'(free_code) > top_code())
        begin
            if (width < TOP_WIDTH)
                width = width + 4'd1;
            else if (n_in > checkpoint)
            begin
                ratio = (64'(n_out) * 64'd100) / 64'(n_in);
                if (ratio > 64'(last_ratio))
                begin
                    pack_code(32'(CODE_CLEAR));
                    width      = 4'(START_WIDTH);
                    free_code  = 14'(CODE_FIRST);
                    n_in       = '0;
                    n_out      = '0;
                    last_ratio = 16'(RATIO_INIT);
                    wipe_table();
                end
                else
                    last_ratio = (ratio > 64'd65535) ? 16'hFFFF : ratio[15:0];
                checkpoint = n_in + 32'(interval);
            end
        end
    endfunction

    function automatic void close_stream();
        pack_code(32'(cur_string));
        if (32'(free_code) == top_code())
            width = width + 4'd1;
        pack_code(32'(CODE_END));
        pack_code(32'd0);
        pack_code(32'd0);
        pack_code(32'd0);
        acc     = '0;
        held    = '0;
        started = 1'b0;
    endfunction

    function automatic void reset_model();
        wipe_table();
        cur_string = '0;
        free_code  = 14'(CODE_FIRST);
        width      = 4'(START_WIDTH);
        n_in       = '0;
        n_out      = '0;
        checkpoint = 32'd100;
        last_ratio = 16'(RATIO_INIT);
        acc        = '0;
        held       = '0;
        started    = 1'b0;
        interval   = DEF_CHECK_INTERVAL;
        expected_bytes.delete();
    endfunction

    initial
    begin
        failures = 0;
        pending  = 0;
        reset_model();
    end

    always @(posedge clk or negedge rst_n)
    begin
        code_beat_t want;
        if (!rst_n)
            reset_model();
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_CHECK_INTERVAL)
                interval = pwdata[15:0];

            if (codes.valid && codes.ready)
            begin
                if (expected_bytes.size() == 0)
                    report("byte with none expected", 32'd0, 32'(codes.out_byte));
                else
                begin
                    want = expected_bytes.pop_front();
                    if (codes.out_byte !== want.out_byte)
                        report("out_byte", 32'(want.out_byte), 32'(codes.out_byte));
                    if (codes.run_last !== want.run_last)
                        report("run_last", 32'(want.run_last), 32'(codes.run_last));
                    if (codes.stream_done !== want.stream_done)
                        report("stream_done", 32'(want.stream_done), 32'(codes.stream_done));
                end
            end

            if (raw.valid && raw.ready)
            begin
                beat_bytes.delete();
                if (!started)
                    open_stream(raw.data_byte);
                else
                    absorb_byte(raw.data_byte);
                if (raw.end_of_stream)
                    close_stream();
                if (beat_bytes.size() > 0)
                begin
                    beat_bytes[beat_bytes.size()-1].run_last    = 1'b1;
                    beat_bytes[beat_bytes.size()-1].stream_done = raw.end_of_stream;
                end
                foreach (beat_bytes[k])
                    expected_bytes.push_back(beat_bytes[k]);
            end
        end
        pending = expected_bytes.size();
    end

endmodule

// File: test/lzw_variable_width_compressor_top_test.sv
`timescale 1ns / 100ps
// Testbench top for the LZW compressor: clock, reset, byte streams, APB writes
// and verdict. Depends on lzwc_pkg, lzwc_if, lzwc_stream_checker and the block.
module lzw_variable_width_compressor_top_test;
    import lzwc_pkg::*;

    // Cycles with no beat on any channel before the run is declared hung.
    // Covers the table sweep, the divider and long stalls.
    localparam int IDLE_LIMIT  = 60000;
    // Quiet time before a register write: bytes that extend a string give no
    // output but keep the block busy probing for a while.
    localparam int SETTLE      = 300;
    localparam int HOLD_CYCLES = 600;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    int                    failures;
    int                    pending;
    int                    idle_cycles;
    bit                    calm;       // no gaps, no stalls
    bit                    hold_req;   // ask the receiver for one long hold-off

    lzwc_raw_if  raw_ch ();
    lzwc_code_if code_ch ();

    lzw_variable_width_compressor_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .raw     (raw_ch),
        .codes   (code_ch)
    );

    lzwc_stream_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .raw      (raw_ch),
        .codes    (code_ch),
        .failures (failures),
        .pending  (pending)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: count cycles in which nothing moves on any port.
    always @(posedge clk)
    begin
        if ((raw_ch.valid && raw_ch.ready) || (code_ch.valid && code_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: bursts of ready and stalls of random length, mostly short.
    // One long hold-off on request so the block backs up and stalls raw.
    initial
    begin
        int pick;
        int len;
        code_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                code_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (calm)
                code_ch.ready <= 1'b1;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    code_ch.ready <= 1'b1;
                    len = $urandom_range(1, 20);
                end
                else if (pick < 94)
                begin
                    code_ch.ready <= 1'b0;
                    len = $urandom_range(1, 3);
                end
                else
                begin
                    code_ch.ready <= 1'b0;
                    len = $urandom_range(20, 60);
                end
                repeat (len - 1) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 60)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    // Offer one byte and hold it until the block takes it. Called right after
    // a rising edge; returns at the edge that accepted the beat.
    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            raw_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        raw_ch.valid         <= 1'b1;
        raw_ch.data_byte     <= value;
        raw_ch.end_of_stream <= last;
        do
            @(posedge clk);
        while (!raw_ch.ready);
    endtask

    // Drain everything expected, then give the block time to finish silent work.
    task automatic drain();
        raw_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_interval(input logic [15:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CHECK_INTERVAL;
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random stream: small alphabets give long string matches, full range gives
    // a miss on almost every byte.
    task automatic random_stream(input int len);
        int alpha;
        alpha = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : 255;
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, alpha)), i == len - 1);
    endtask

    initial
    begin
        int left;
        int len;
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        raw_ch.valid         = 1'b0;
        raw_ch.data_byte     = '0;
        raw_ch.end_of_stream = 1'b0;
        idle_cycles          = 0;
        calm                 = 1'b0;
        hold_req             = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-byte streams at both byte extremes (start and end on
        // the same beat), a run of one byte that keeps hitting the table, and
        // a short mixed stream, then a two-byte stream of one repeated byte.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        for (int i = 0; i < 10; i++)
            send_byte(8'hAA, i == 9);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h7F, 1'b1);

        // Random short streams at the top interval, then a random interval.
        write_interval(16'hFFFF);
        left = 60;
        while (left > 0)
        begin
            len  = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 30);
            len  = (len > left) ? left : len;
            calm = ($urandom_range(0, 3) == 0);
            random_stream(len);
            left -= len;
        end
        calm = 1'b0;
        write_interval(16'($urandom_range(1, 65535)));
        left = 70;
        while (left > 0)
        begin
            len  = $urandom_range(1, 40);
            len  = (len > left) ? left : len;
            calm = ($urandom_range(0, 4) == 0);
            random_stream(len);
            left -= len;
        end
        calm = 1'b0;

        // Pressure: random bytes offered back to back while the receiver holds
        // off long enough to back the block up and stall raw.
        write_interval(16'd1);
        calm = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            if (i == 10)
                hold_req = 1'b1;
            send_byte(8'($urandom_range(0, 255)), i == 39);
        end
        calm = 1'b0;

        write_interval(DEF_CHECK_INTERVAL);
        random_stream(20);

        raw_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        wait (pending == 0);
        repeat (200) @(posedge clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
design/lzwc_pkg.sv
design/lzwc_if.sv
design/lzwc_table.sv
design/lzwc_div.sv
design/lzw_variable_width_compressor_top.sv
test/lzwc_stream_checker.sv
test/lzw_variable_width_compressor_top_test.sv
